// ----- design/rwlqr_pkg.sv -----
// ----------------------------------------------------------------------------
// rwlqr_pkg: shared types and constants of the reaction wheel balance block
// Control word layout, register map, reset values and the step program.
// ----------------------------------------------------------------------------
package rwlqr_pkg;

  // register indexes on the configuration port
  localparam logic [2:0] RegAlpha       = 3'd0;
  localparam logic [2:0] RegKPitch      = 3'd1;
  localparam logic [2:0] RegKRate       = 3'd2;
  localparam logic [2:0] RegKWheel      = 3'd3;
  localparam logic [2:0] RegPitchLimit  = 3'd4;
  localparam logic [2:0] RegStillLimit  = 3'd5;
  localparam logic [2:0] RegDampingGain = 3'd6;

  localparam int unsigned PaddrW = 5;

  // reset values
  localparam logic [16:0] AlphaReset       = 17'd0;
  localparam logic [31:0] KReset           = 32'd0;
  localparam logic [22:0] PitchLimitReset  = 23'd819;
  localparam logic [22:0] StillLimitReset  = 23'd41;
  localparam logic [31:0] DampingGainReset = 32'd26214;

  localparam logic [16:0] AlphaOne = 17'h10000;

  // datapath widths
  localparam int unsigned OpaW  = 33;
  localparam int unsigned OpbW  = 25;
  localparam int unsigned ProdW = OpaW + OpbW;
  localparam int unsigned AccW  = ProdW + 2;

  // step program
  localparam int unsigned StepW = 4;
  localparam logic [StepW-1:0] StepAlpha  = 4'd0;
  localparam logic [StepW-1:0] StepUpdate = 4'd1;
  localparam logic [StepW-1:0] StepCheck  = 4'd2;
  localparam logic [StepW-1:0] StepKp     = 4'd3;
  localparam logic [StepW-1:0] StepKr     = 4'd4;
  localparam logic [StepW-1:0] StepKw     = 4'd5;
  localparam logic [StepW-1:0] StepSumKw  = 4'd6;
  localparam logic [StepW-1:0] StepDamp   = 4'd7;
  localparam logic [StepW-1:0] StepSumDg  = 4'd8;
  localparam logic [StepW-1:0] StepEmit   = 4'd9;

  typedef enum logic [2:0] {
    MUL_ALPHA,
    MUL_KP,
    MUL_KR,
    MUL_KW,
    MUL_DG
  } mul_sel_e;

  typedef enum logic [1:0] {
    ACC_HOLD,
    ACC_CLR,
    ACC_SUB
  } acc_op_e;

  typedef enum logic [1:0] {
    OFF_HOLD,
    OFF_UPD,
    OFF_CLR_IF
  } off_op_e;

  typedef enum logic [1:0] {
    JMP_NONE,
    JMP_DAMP,
    JMP_ALWAYS
  } jmp_e;

  typedef struct packed {
    mul_sel_e         mul;
    acc_op_e          acc;
    off_op_e          off;
    jmp_e             jmp;
    logic [StepW-1:0] target;
    logic             emit;
  } ctrl_t;

  function automatic ctrl_t rom_word(input logic [StepW-1:0] step);
    ctrl_t w;
    w = '{mul: MUL_ALPHA, acc: ACC_HOLD, off: OFF_HOLD, jmp: JMP_NONE,
          target: StepAlpha, emit: 1'b0};
    case (step)
      StepAlpha:  w.acc = ACC_CLR;
      StepUpdate: w.off = OFF_UPD;
      StepCheck: begin
        w.off    = OFF_CLR_IF;
        w.jmp    = JMP_DAMP;
        w.target = StepDamp;
      end
      StepKp:     w.mul = MUL_KP;
      StepKr: begin
        w.mul = MUL_KR;
        w.acc = ACC_SUB;
      end
      StepKw: begin
        w.mul = MUL_KW;
        w.acc = ACC_SUB;
      end
      StepSumKw: begin
        w.acc    = ACC_SUB;
        w.jmp    = JMP_ALWAYS;
        w.target = StepEmit;
      end
      StepDamp:   w.mul = MUL_DG;
      StepSumDg:  w.acc = ACC_SUB;
      StepEmit:   w.emit = 1'b1;
      default:    w.emit = 1'b1;
    endcase
    return w;
  endfunction

endpackage

// ----- design/reaction_wheel_lqr_balance.sv -----
// ----------------------------------------------------------------------------
// reaction_wheel_lqr_balance: state feedback balance controller
// Low-pass pitch offset, wheel damping fallback and saturated torque output.
// ----------------------------------------------------------------------------
// One sample word (pitch angle, pitch rate, wheel speed) is taken when the
// block is free and turned into one torque word. A small step program in a
// table drives one shared 33 x 25 bit multiplier, an accumulator and the
// offset register, one step at a time. The damping path skips the gain steps
// of the balance path. The block takes no new sample until its result has been
// moved into the output register, which waits while that register still holds
// an unread result. A finished result waits in the output register while the
// next sample is taken. Configuration goes through the APB port (register i at
// byte address 4*i); the user must write it only while idle, not enforced here.

module reaction_wheel_lqr_balance (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic signed [23:0]            pitch_angle_i,
  input  logic signed [23:0]            pitch_rate_i,
  input  logic signed [23:0]            wheel_speed_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic signed [23:0]            torque_command_o,
  output logic                          damping_mode_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [rwlqr_pkg::PaddrW-1:0]  paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);

  // configuration registers
  logic [16:0] alpha_q;
  logic [31:0] k_pitch_q, k_rate_q, k_wheel_q, damping_gain_q;
  logic [22:0] pitch_limit_q, still_limit_q;
  logic [2:0]  reg_idx;
  logic        cfg_wr;

  assign pready  = 1'b1;
  assign reg_idx = paddr[rwlqr_pkg::PaddrW-1:2];
  assign cfg_wr  = psel & penable & pwrite & pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alpha_q        <= rwlqr_pkg::AlphaReset;
      k_pitch_q      <= rwlqr_pkg::KReset;
      k_rate_q       <= rwlqr_pkg::KReset;
      k_wheel_q      <= rwlqr_pkg::KReset;
      pitch_limit_q  <= rwlqr_pkg::PitchLimitReset;
      still_limit_q  <= rwlqr_pkg::StillLimitReset;
      damping_gain_q <= rwlqr_pkg::DampingGainReset;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        rwlqr_pkg::RegAlpha:       alpha_q        <= pwdata[16:0];
        rwlqr_pkg::RegKPitch:      k_pitch_q      <= pwdata;
        rwlqr_pkg::RegKRate:       k_rate_q       <= pwdata;
        rwlqr_pkg::RegKWheel:      k_wheel_q      <= pwdata;
        rwlqr_pkg::RegPitchLimit:  pitch_limit_q  <= pwdata[22:0];
        rwlqr_pkg::RegStillLimit:  still_limit_q  <= pwdata[22:0];
        rwlqr_pkg::RegDampingGain: damping_gain_q <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      rwlqr_pkg::RegAlpha:       prdata = {15'd0, alpha_q};
      rwlqr_pkg::RegKPitch:      prdata = k_pitch_q;
      rwlqr_pkg::RegKRate:       prdata = k_rate_q;
      rwlqr_pkg::RegKWheel:      prdata = k_wheel_q;
      rwlqr_pkg::RegPitchLimit:  prdata = {9'd0, pitch_limit_q};
      rwlqr_pkg::RegStillLimit:  prdata = {9'd0, still_limit_q};
      rwlqr_pkg::RegDampingGain: prdata = damping_gain_q;
      default:                   prdata = 32'd0;
    endcase
  end

  // sequencer
  logic                         busy_q;
  logic [rwlqr_pkg::StepW-1:0]  step_q, step_d;
  rwlqr_pkg::ctrl_t             cw;
  logic                         in_acc, emit_go;

  logic signed [23:0] pitch_q, rate_q, speed_q;
  logic signed [23:0] off_q, off_d;
  logic signed [rwlqr_pkg::ProdW-1:0] prod_q;
  logic signed [rwlqr_pkg::AccW-1:0]  acc_q, acc_d;
  logic                         damp_q;
  logic                         out_valid_q;
  logic signed [23:0]           torque_q;
  logic                         out_damp_q;

  assign cw         = rwlqr_pkg::rom_word(step_q);
  assign in_ready_o = ~busy_q;
  assign in_acc     = in_valid_i & in_ready_o;
  // result register is free or being emptied this cycle
  assign emit_go    = busy_q & cw.emit & (~out_valid_q | out_ready_i);

  // offset and wheel checks
  logic [23:0] off_mag, spd_mag;
  logic        over, still, damp_cond;

  assign off_mag   = off_q[23] ? 24'(-off_q) : 24'(off_q);
  assign spd_mag   = speed_q[23] ? 24'(-speed_q) : 24'(speed_q);
  assign over      = off_mag > {1'b0, pitch_limit_q};
  assign still     = spd_mag < {1'b0, still_limit_q};
  assign damp_cond = over & ~still;

  // multiplier operands
  logic [16:0]                        alpha_eff;
  logic signed [rwlqr_pkg::OpaW-1:0]  opa;
  logic signed [rwlqr_pkg::OpbW-1:0]  opb, diff;

  assign alpha_eff = (alpha_q > rwlqr_pkg::AlphaOne) ? rwlqr_pkg::AlphaOne : alpha_q;
  assign diff      = $signed({pitch_q[23], pitch_q}) - $signed({off_q[23], off_q});

  always_comb begin
    unique case (cw.mul)
      rwlqr_pkg::MUL_ALPHA: begin
        opa = $signed({16'd0, alpha_eff});
        opb = diff;
      end
      rwlqr_pkg::MUL_KP: begin
        opa = $signed({k_pitch_q[31], k_pitch_q});
        opb = diff;
      end
      rwlqr_pkg::MUL_KR: begin
        opa = $signed({k_rate_q[31], k_rate_q});
        opb = $signed({rate_q[23], rate_q});
      end
      rwlqr_pkg::MUL_KW: begin
        opa = $signed({k_wheel_q[31], k_wheel_q});
        opb = $signed({speed_q[23], speed_q});
      end
      rwlqr_pkg::MUL_DG: begin
        opa = $signed({1'b0, damping_gain_q});
        opb = $signed({speed_q[23], speed_q});
      end
      default: begin
        opa = '0;
        opb = '0;
      end
    endcase
  end

  // offset and accumulator update
  logic signed [rwlqr_pkg::ProdW-1:0] prod_rnd;

  assign prod_rnd = (prod_q + rwlqr_pkg::ProdW'(32768)) >>> 16;

  always_comb begin
    off_d = off_q;
    unique case (cw.off)
      rwlqr_pkg::OFF_HOLD:   off_d = off_q;
      // the filtered value stays between old offset and pitch, no wrap
      rwlqr_pkg::OFF_UPD:    off_d = off_q + prod_rnd[23:0];
      rwlqr_pkg::OFF_CLR_IF: off_d = (over & still) ? 24'sd0 : off_q;
      default:               off_d = off_q;
    endcase
  end

  always_comb begin
    unique case (cw.acc)
      rwlqr_pkg::ACC_HOLD: acc_d = acc_q;
      rwlqr_pkg::ACC_CLR:  acc_d = '0;
      // products go in negated, the torque is minus the sum
      rwlqr_pkg::ACC_SUB:  acc_d = acc_q - rwlqr_pkg::AccW'(prod_q);
      default:             acc_d = acc_q;
    endcase
  end

  always_comb begin
    step_d = step_q + 1'b1;
    unique case (cw.jmp)
      rwlqr_pkg::JMP_NONE:   step_d = step_q + 1'b1;
      rwlqr_pkg::JMP_DAMP:   step_d = damp_cond ? cw.target : step_q + 1'b1;
      rwlqr_pkg::JMP_ALWAYS: step_d = cw.target;
      default:               step_d = step_q + 1'b1;
    endcase
  end

  // rounding and saturation of the torque
  logic signed [rwlqr_pkg::AccW-1:0] acc_rnd;
  logic signed [23:0]                torque_sat;

  assign acc_rnd = (acc_q + rwlqr_pkg::AccW'(32768)) >>> 16;

  always_comb begin
    if (acc_rnd > rwlqr_pkg::AccW'(8388607)) begin
      torque_sat = 24'sh7fffff;
    end else if (acc_rnd < -rwlqr_pkg::AccW'(8388608)) begin
      torque_sat = -24'sh800000;
    end else begin
      torque_sat = acc_rnd[23:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      step_q      <= rwlqr_pkg::StepAlpha;
      off_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_acc) begin
        busy_q <= 1'b1;
        step_q <= rwlqr_pkg::StepAlpha;
      end else if (busy_q) begin
        if (cw.emit) begin
          if (emit_go) begin
            busy_q <= 1'b0;
          end
        end else begin
          step_q <= step_d;
          off_q  <= off_d;
        end
      end
      if (emit_go) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      pitch_q <= pitch_angle_i;
      rate_q  <= pitch_rate_i;
      speed_q <= wheel_speed_i;
    end
    if (busy_q) begin
      prod_q <= opa * opb;
      acc_q  <= acc_d;
      if (step_q == rwlqr_pkg::StepCheck) begin
        damp_q <= damp_cond;
      end
    end
    if (emit_go) begin
      torque_q   <= torque_sat;
      out_damp_q <= damp_q;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign torque_command_o = torque_q;
  assign damping_mode_o   = out_damp_q;

  // checks
  a_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> busy_q && step_q == rwlqr_pkg::StepAlpha)
    else $error("program did not start at its first step");

  a_step_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> step_q <= rwlqr_pkg::StepEmit)
    else $error("step counter left the program");

  a_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q && step_q == rwlqr_pkg::StepCheck && over && still |=> off_q == 24'sd0)
    else $error("offset not cleared with the wheel still");

  a_damp_branch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q && step_q == rwlqr_pkg::StepCheck && damp_cond
      |=> step_q == rwlqr_pkg::StepDamp && $stable(off_q))
    else $error("damping branch not taken or offset disturbed");

  a_hold_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_ready_i |=> $stable(torque_q) && $stable(out_damp_q))
    else $error("waiting result overwritten");

endmodule

// ----- dv/tb_reaction_wheel_lqr_balance.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_reaction_wheel_lqr_balance: self-checking bench for the balance controller
// Samples are queued and driven with random gaps. Each accepted sample is run
// through a local fixed-point model of the offset filter, damping fallback
// and LQR torque law, and the resulting torque word is compared with the
// block's output. The gain and limit registers are rewritten over APB
// between phases once the block has drained.
// ----------------------------------------------------------------------------
module tb_reaction_wheel_lqr_balance;

  localparam logic [2:0] RegUnused = 3'd7;
  localparam longint SigMax = 64'sd8388607;
  localparam longint SigMin = -64'sd8388608;
  localparam int NumPhases = 12;
  localparam int PhaseSamples = 160;
  localparam int LongHold = 400;
  localparam int WatchdogLimit = 3000;

  typedef struct packed {
    logic signed [23:0] pitch;
    logic signed [23:0] rate;
    logic signed [23:0] speed;
    logic [3:0]         gap;
  } sample_t;

  typedef struct packed {
    logic signed [23:0] torque;
    logic               damp;
  } torque_word_t;

  logic                          clk_i;
  logic                          rst_ni;
  logic                          in_valid_i;
  logic                          in_ready_o;
  logic signed [23:0]            pitch_angle_i;
  logic signed [23:0]            pitch_rate_i;
  logic signed [23:0]            wheel_speed_i;
  logic                          out_valid_o;
  logic                          out_ready_i;
  logic signed [23:0]            torque_command_o;
  logic                          damping_mode_o;
  logic                          psel;
  logic                          penable;
  logic                          pwrite;
  logic [rwlqr_pkg::PaddrW-1:0]  paddr;
  logic [31:0]                   pwdata;
  logic [31:0]                   prdata;
  logic                          pready;

  reaction_wheel_lqr_balance u_top (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .pitch_angle_i    (pitch_angle_i),
    .pitch_rate_i     (pitch_rate_i),
    .wheel_speed_i    (wheel_speed_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .torque_command_o (torque_command_o),
    .damping_mode_o   (damping_mode_o),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  // controller shadow state
  longint alpha_w;
  longint kp_w;
  longint kr_w;
  longint kw_w;
  longint plim_w;
  longint slim_w;
  longint dgain_w;
  longint offset_w;

  sample_t      sample_q[$];
  torque_word_t torque_exp_q[$];
  sample_t      next_sample;
  torque_word_t got_word;
  torque_word_t exp_word;
  logic         staged;
  int unsigned  gap_max;
  int unsigned  stall_max;
  int unsigned  stall_left;
  int unsigned  hold_req;
  int unsigned  hold_done;
  int unsigned  err_cnt;
  int unsigned  idle_cycles;

  function automatic longint rnd16(input longint v);
    return (v + 64'sd32768) >>> 16;
  endfunction

  function automatic longint sat24(input longint v);
    if (v > SigMax) return SigMax;
    if (v < SigMin) return SigMin;
    return v;
  endfunction

  function automatic longint mag64(input longint v);
    return (v < 0) ? -v : v;
  endfunction

  function automatic torque_word_t balance_torque(input logic signed [23:0] pa,
                                                  input logic signed [23:0] pr,
                                                  input logic signed [23:0] ws);
    longint a;
    longint p;
    longint r;
    longint s;
    longint acc;
    torque_word_t w;
    a = (alpha_w > longint'(rwlqr_pkg::AlphaOne)) ? longint'(rwlqr_pkg::AlphaOne) : alpha_w;
    p = longint'(pa);
    r = longint'(pr);
    s = longint'(ws);
    offset_w = sat24(offset_w + rnd16(a * (p - offset_w)));
    if (mag64(offset_w) > plim_w && mag64(s) >= slim_w) begin
      w.torque = 24'(sat24(rnd16(-(dgain_w * s))));
      w.damp = 1'b1;
    end else begin
      // wheel nearly still: drop the offset and keep balancing
      if (mag64(offset_w) > plim_w) offset_w = 0;
      acc = kp_w * (p - offset_w) + kr_w * r + kw_w * s;
      w.torque = 24'(sat24(rnd16(-acc)));
      w.damp = 1'b0;
    end
    return w;
  endfunction

  function automatic logic signed [23:0] rand_sig(input longint lim);
    longint span;
    longint v;
    span = (lim < 100000) ? 2 * lim + 64 : 100000;
    case ($urandom_range(0, 5))
      0, 1: v = longint'($urandom());
      2: v = longint'($urandom_range(0, 32'(2 * span))) - span;
      3: begin
        case ($urandom_range(0, 4))
          0: v = SigMax;
          1: v = SigMin;
          2: v = 0;
          3: v = 1;
          default: v = -1;
        endcase
      end
      default: begin
        v = lim + longint'($urandom_range(0, 2)) - 1;
        if ($urandom_range(0, 1) == 0) v = -v;
      end
    endcase
    return 24'(v);
  endfunction

  function automatic logic [31:0] rand_gain();
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return $urandom();
      3: return 32'd0;
      default: return $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
    endcase
  endfunction

  function automatic logic [31:0] rand_limit();
    case ($urandom_range(0, 4))
      0: return 32'd0;
      1: return 32'h007f_ffff;
      2: return $urandom() & 32'h007f_ffff;
      default: return $urandom_range(0, 16384);
    endcase
  endfunction

  task automatic set_reg(input logic [2:0] idx, input logic [31:0] val);
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      rwlqr_pkg::RegAlpha:       alpha_w = longint'(val[16:0]);
      rwlqr_pkg::RegKPitch:      kp_w = longint'($signed(val));
      rwlqr_pkg::RegKRate:       kr_w = longint'($signed(val));
      rwlqr_pkg::RegKWheel:      kw_w = longint'($signed(val));
      rwlqr_pkg::RegPitchLimit:  plim_w = longint'(val[22:0]);
      rwlqr_pkg::RegStillLimit:  slim_w = longint'(val[22:0]);
      rwlqr_pkg::RegDampingGain: dgain_w = longint'(val);
      default: ;
    endcase
  endtask

  task automatic queue_sample(input longint p, input longint r, input longint s);
    sample_t smp;
    smp.pitch = 24'(p);
    smp.rate = 24'(r);
    smp.speed = 24'(s);
    smp.gap = 4'($urandom_range(0, gap_max));
    sample_q.push_back(smp);
  endtask

  task automatic wait_drained();
    while (sample_q.size() != 0 || staged || in_valid_i || torque_exp_q.size() != 0)
      @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic load_settings(input int phase);
    logic [31:0] a;
    if (phase == 0) begin
      set_reg(rwlqr_pkg::RegAlpha, 32'd0);
      set_reg(rwlqr_pkg::RegKPitch, 32'h8000_0000);
      set_reg(rwlqr_pkg::RegKRate, 32'h8000_0000);
      set_reg(rwlqr_pkg::RegKWheel, 32'h8000_0000);
      set_reg(rwlqr_pkg::RegPitchLimit, 32'd0);
      set_reg(rwlqr_pkg::RegStillLimit, 32'd0);
      set_reg(rwlqr_pkg::RegDampingGain, 32'd0);
    end else if (phase == 1) begin
      set_reg(rwlqr_pkg::RegAlpha, 32'h0001_ffff);
      set_reg(rwlqr_pkg::RegKPitch, 32'h7fff_ffff);
      set_reg(rwlqr_pkg::RegKRate, 32'h7fff_ffff);
      set_reg(rwlqr_pkg::RegKWheel, 32'h7fff_ffff);
      set_reg(rwlqr_pkg::RegPitchLimit, 32'h007f_ffff);
      set_reg(rwlqr_pkg::RegStillLimit, 32'h007f_ffff);
      set_reg(rwlqr_pkg::RegDampingGain, 32'hffff_ffff);
    end else begin
      case ($urandom_range(0, 5))
        0: a = 32'd1;
        1: a = 32'd65535;
        2: a = 32'(rwlqr_pkg::AlphaOne);
        3: a = $urandom_range(65537, 131071);
        default: a = $urandom_range(0, 65536);
      endcase
      set_reg(rwlqr_pkg::RegAlpha, a);
      set_reg(rwlqr_pkg::RegKPitch, rand_gain());
      set_reg(rwlqr_pkg::RegKRate, rand_gain());
      set_reg(rwlqr_pkg::RegKWheel, rand_gain());
      set_reg(rwlqr_pkg::RegPitchLimit, rand_limit());
      set_reg(rwlqr_pkg::RegStillLimit, rand_limit());
      set_reg(rwlqr_pkg::RegDampingGain,
              $urandom_range(0, 3) == 0 ? 32'hffff_ffff : $urandom());
    end
  endtask

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // sample driver
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      staged = 1'b0;
    end else begin
      if (in_valid_i && in_ready_o)
        torque_exp_q.push_back(balance_torque(pitch_angle_i, pitch_rate_i, wheel_speed_i));
      if (!in_valid_i || in_ready_o) begin
        if (!staged && sample_q.size() != 0) begin
          next_sample = sample_q.pop_front();
          staged = 1'b1;
        end
        if (staged && next_sample.gap == 0) begin
          in_valid_i <= 1'b1;
          pitch_angle_i <= next_sample.pitch;
          pitch_rate_i <= next_sample.rate;
          wheel_speed_i <= next_sample.speed;
          staged = 1'b0;
        end else begin
          in_valid_i <= 1'b0;
          if (staged) next_sample.gap = next_sample.gap - 4'd1;
        end
      end
    end
  end

  // torque word monitor
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        got_word.torque = torque_command_o;
        got_word.damp = damping_mode_o;
        if (torque_exp_q.size() == 0) begin
          if (err_cnt < 10)
            $display("error: unexpected word torque %0d damp %0b", got_word.torque,
                     got_word.damp);
          err_cnt++;
        end else begin
          exp_word = torque_exp_q.pop_front();
          if (got_word.torque !== exp_word.torque) begin
            if (err_cnt < 10)
              $display("error: torque exp %0d got %0d", exp_word.torque, got_word.torque);
            err_cnt++;
          end
          if (got_word.damp !== exp_word.damp) begin
            if (err_cnt < 10)
              $display("error: damping flag exp %0b got %0b", exp_word.damp, got_word.damp);
            err_cnt++;
          end
        end
        stall_left = $urandom_range(0, stall_max);
      end
      // long hold-off so the block backs up onto its input
      if (hold_req != hold_done) begin
        hold_done = hold_req;
        stall_left = LongHold;
      end
      if (stall_left != 0) begin
        stall_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
          (!in_valid_i && torque_exp_q.size() == 0))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= WatchdogLimit) begin
        $display("reaction_wheel_lqr_balance: mismatch");
        $finish;
      end
    end
  end

  initial begin
    int phase;
    int n;
    int run_left;
    longint base_pitch;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    pitch_angle_i = '0;
    pitch_rate_i = '0;
    wheel_speed_i = '0;
    out_ready_i = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    staged = 1'b0;
    gap_max = 10;
    stall_max = 10;
    hold_req = 0;
    hold_done = 0;
    err_cnt = 0;
    idle_cycles = 0;
    alpha_w = longint'(rwlqr_pkg::AlphaReset);
    kp_w = 0;
    kr_w = 0;
    kw_w = 0;
    plim_w = longint'(rwlqr_pkg::PitchLimitReset);
    slim_w = longint'(rwlqr_pkg::StillLimitReset);
    dgain_w = longint'(rwlqr_pkg::DampingGainReset);
    offset_w = 0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset limits and damping gain, offset tracks pitch exactly
    set_reg(rwlqr_pkg::RegAlpha, 32'(rwlqr_pkg::AlphaOne));
    queue_sample(820, 0, 41);
    queue_sample(820, 0, -40);
    queue_sample(-819, 5, 100);
    queue_sample(-820, 0, SigMin);
    wait_drained();

    set_reg(rwlqr_pkg::RegAlpha, 32'h0001_ffff);
    set_reg(rwlqr_pkg::RegKPitch, 32'h0010_0000);
    set_reg(rwlqr_pkg::RegKRate, 32'hfffc_0000);
    set_reg(rwlqr_pkg::RegKWheel, 32'h0000_c000);
    set_reg(rwlqr_pkg::RegPitchLimit, 32'd4096);
    set_reg(rwlqr_pkg::RegStillLimit, 32'd2048);
    set_reg(rwlqr_pkg::RegDampingGain, 32'hffff_ffff);
    set_reg(RegUnused, $urandom());
    queue_sample(0, 0, 0);
    queue_sample(4096, 100, 2048);
    queue_sample(4097, 0, 2048);
    queue_sample(4097, -3, 2047);
    queue_sample(-4097, 0, -2048);
    queue_sample(-4097, 9, -2047);
    queue_sample(SigMax, SigMax, SigMax);
    queue_sample(SigMin, SigMin, SigMin);
    queue_sample(0, SigMax, 0);
    queue_sample(0, SigMin, 0);
    queue_sample(1, -1, 1);
    queue_sample(-1, 1, -1);
    queue_sample(4096, SigMax, -2047);
    queue_sample(-4096, SigMin, 2047);

    for (phase = 0; phase < NumPhases; phase++) begin
      wait_drained();
      load_settings(phase);
      gap_max = (phase % 3 == 2) ? 0 : 10;
      stall_max = (phase % 4 == 3) ? 0 : 10;
      if (phase == 4) begin
        gap_max = 0;
        hold_req++;
      end
      run_left = 0;
      base_pitch = 0;
      for (n = 0; n < PhaseSamples; n++) begin
        // hold the tilt for a run of 1 to 8 samples so the offset filter can settle
        if (run_left == 0) begin
          base_pitch = rand_sig(plim_w);
          run_left = $urandom_range(1, 8);
        end
        run_left--;
        queue_sample(base_pitch + longint'($urandom_range(0, 8)) - 4, rand_sig(plim_w),
                     rand_sig(slim_w));
      end
    end

    wait_drained();
    repeat (20) @(posedge clk_i);
    if (err_cnt == 0 && torque_exp_q.size() == 0) begin
      $display("reaction_wheel_lqr_balance: match");
    end else begin
      $display("reaction_wheel_lqr_balance: mismatch");
    end
    $finish;
  end

endmodule
